/* sv/eclk_pkg.sv */
// ----------------------------------------------------------------------------
// eclk_pkg: shared types and calendar helpers
// request and response payloads, queue entry, back-end states, date constants
// ----------------------------------------------------------------------------
package eclk_pkg;

   typedef enum logic [1:0] {
      OP_READ = 2'd0,
      OP_TICK = 2'd1,
      OP_SYNC = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] sync_seconds;
   } req_type;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [2:0] weekday;
      logic [7:0] year_since_1900;
      logic [3:0] month_index;
      logic [4:0] day_of_month;
      logic       sync_request;
      logic       is_synced;
   } rsp_type;

   // one queued conversion job
   typedef struct packed {
      logic [31:0] epoch_seconds;
      logic        sync_request;
      logic        is_synced;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DAY,
      BK_SOD,
      BK_MOD,
      BK_HMS,
      BK_YEAR,
      BK_MONTH,
      BK_DONE
   } back_state_type;

   localparam logic [31:0] EPOCH_RESET    = 32'd10886400;
   localparam logic [15:0] INTERVAL_RESET = 16'd600;

   // reciprocals for the constant divides, each exact over its input range
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // ceil(2^35 / 675), 25-bit input
   localparam logic [9:0]  DAY_DIV128 = 10'd675;       // 86400 / 128
   localparam logic [15:0] MOD_RECIP  = 16'd34953;     // ceil(2^19 / 15), 15-bit input
   localparam logic [9:0]  HOUR_RECIP = 10'd547;       // ceil(2^13 / 15), 9-bit input

   localparam logic [7:0] FIRST_YEAR    = 8'd70;
   localparam logic [2:0] FIRST_WEEKDAY = 3'd4;
   localparam logic [7:0] YEAR_2100     = 8'd200;
   localparam logic [8:0] DAYS_YEAR     = 9'd365;
   localparam logic [8:0] DAYS_LEAP     = 9'd366;
   localparam logic [3:0] MONTH_FEB     = 4'd1;
   localparam logic [4:0] FEB_LEAP_DAYS = 5'd29;
   localparam logic [4:0] FOUR_WEEKS    = 5'd28;

   // years 1970..2155: multiple of four except 2100
   function automatic logic is_leap(input logic [7:0] year);
      return (year[1:0] == 2'b00) && (year != YEAR_2100);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd0:      len = 5'd31;
         MONTH_FEB: len = leap ? FEB_LEAP_DAYS : 5'd28;
         4'd2:      len = 5'd31;
         4'd3:      len = 5'd30;
         4'd4:      len = 5'd31;
         4'd5:      len = 5'd30;
         4'd6:      len = 5'd31;
         4'd7:      len = 5'd31;
         4'd8:      len = 5'd30;
         4'd9:      len = 5'd31;
         4'd10:     len = 5'd30;
         default:   len = 5'd31;
      endcase
      return len;
   endfunction

   // a and b both below 7
   function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
      logic [3:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 4'd7) begin
         s = s - 4'd7;
      end
      return s[2:0];
   endfunction

   function automatic logic [2:0] mod7_small(input logic [4:0] v);
      logic [4:0] r;
      r = v;
      for (int i = 0; i < 4; i++) begin
         if (r >= 5'd7) begin
            r = r - 5'd7;
         end
      end
      return r[2:0];
   endfunction

endpackage

/* sv/eclk_front.sv */
// ----------------------------------------------------------------------------
// eclk_front: clock state and request decode
// applies ticks and syncs to the seconds count, raises sync requests, queues jobs
// ----------------------------------------------------------------------------
module eclk_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  eclk_pkg::req_type req_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data,
   output logic             push,
   output eclk_pkg::job_type push_data,
   input  logic             full
);
   import eclk_pkg::*;

   logic [31:0] epoch_ff, epoch_in;
   logic        synced_ff, synced_in;
   logic [15:0] ticks_ff, ticks_in;
   logic [15:0] interval_ff, interval_in;
   logic [15:0] ticks_base;
   logic        request;
   logic        accept;

   assign req_ready = !full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !full;

   always_comb begin
      epoch_in    = epoch_ff;
      synced_in   = synced_ff;
      ticks_in    = ticks_ff;
      interval_in = interval_ff;
      ticks_base  = ticks_ff;
      request     = 1'b0;
      if (csr_valid) begin
         interval_in = csr_data;
      end
      if (accept) begin
         unique case (req_data.opcode)
            OP_TICK: begin
               // request check comes before the count moves
               if (!synced_ff || ticks_ff >= interval_ff) begin
                  request    = 1'b1;
                  ticks_base = '0;
               end
               epoch_in = epoch_ff + 32'd1;
               ticks_in = ticks_base + 16'd1;
            end
            OP_SYNC: begin
               epoch_in  = req_data.sync_seconds;
               synced_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   assign push                    = accept;
   assign push_data.epoch_seconds = epoch_in;
   assign push_data.sync_request  = request;
   assign push_data.is_synced     = synced_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff    <= EPOCH_RESET;
         synced_ff   <= 1'b0;
         ticks_ff    <= '0;
         interval_ff <= INTERVAL_RESET;
      end else begin
         epoch_ff    <= epoch_in;
         synced_ff   <= synced_in;
         ticks_ff    <= ticks_in;
         interval_ff <= interval_in;
      end
   end

endmodule

/* sv/eclk_queue.sv */
// ----------------------------------------------------------------------------
// eclk_queue: job queue between front and back
// small first-in first-out buffer of conversion jobs
// ----------------------------------------------------------------------------
module eclk_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  eclk_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output eclk_pkg::job_type pop_data,
   output logic             empty
);
   import eclk_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/eclk_back.sv */
// ----------------------------------------------------------------------------
// eclk_back: seconds to calendar conversion
// reciprocal multiplies for day and time of day, then year and month walks
// ----------------------------------------------------------------------------
module eclk_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             empty,
   output logic             pop,
   input  eclk_pkg::job_type pop_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output eclk_pkg::rsp_type rsp_data
);
   import eclk_pkg::*;

   back_state_type state_ff, state_in;
   logic [31:0] secs_ff, secs_in;
   logic [16:0] rem_ff, rem_in;
   logic [10:0] mins_ff, mins_in;
   logic [15:0] t_ff, t_in;
   logic [7:0]  year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [2:0]  wd_ff, wd_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  second_ff, second_in;
   logic        sreq_ff, sreq_in;
   logic        synced_ff, synced_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_load;

   logic [50:0] day_prod;
   logic [19:0] day_back;
   logic [30:0] mod_prod;
   logic [18:0] hour_prod;
   logic [16:0] mins_x60;
   logic [16:0] sec_diff;
   logic [10:0] hour_x60;
   logic [10:0] min_diff;
   logic        leap;
   logic [8:0]  year_len;
   logic [4:0]  mlen;

   // days = (secs / 128) / 675
   assign day_prod  = secs_ff[31:7] * DAY_RECIP;
   // low 17 bits of days * 86400, enough since seconds of day fit in 17 bits
   assign day_back  = t_ff[9:0] * DAY_DIV128;
   // minute of day = (seconds of day / 4) / 15
   assign mod_prod  = rem_ff[16:2] * MOD_RECIP;
   // hour = (minute of day / 4) / 15
   assign hour_prod = mins_ff[10:2] * HOUR_RECIP;
   assign mins_x60  = {mins_ff, 6'b0} - {4'b0, mins_ff, 2'b0};
   assign sec_diff  = rem_ff - mins_x60;
   assign hour_x60  = {hour_ff, 6'b0} - {4'b0, hour_ff, 2'b0};
   assign min_diff  = mins_ff - hour_x60;

   assign leap      = is_leap(year_ff);
   assign year_len  = leap ? DAYS_LEAP : DAYS_YEAR;
   assign mlen      = month_len(month_ff, leap);

   always_comb begin
      state_in  = state_ff;
      secs_in   = secs_ff;
      rem_in    = rem_ff;
      mins_in   = mins_ff;
      t_in      = t_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      wd_in     = wd_ff;
      hour_in   = hour_ff;
      second_in = second_ff;
      sreq_in   = sreq_ff;
      synced_in = synced_ff;
      pop       = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!empty) begin
               pop       = 1'b1;
               secs_in   = pop_data.epoch_seconds;
               sreq_in   = pop_data.sync_request;
               synced_in = pop_data.is_synced;
               state_in  = BK_DAY;
            end
         end
         BK_DAY: begin
            t_in     = day_prod[50:35];
            state_in = BK_SOD;
         end
         BK_SOD: begin
            rem_in   = secs_ff[16:0] - {day_back[9:0], 7'b0};
            state_in = BK_MOD;
         end
         BK_MOD: begin
            mins_in  = mod_prod[29:19];
            state_in = BK_HMS;
         end
         BK_HMS: begin
            hour_in   = hour_prod[17:13];
            second_in = sec_diff[5:0];
            year_in   = FIRST_YEAR;
            wd_in     = FIRST_WEEKDAY;
            state_in  = BK_YEAR;
         end
         BK_YEAR: begin
            if (t_ff < {7'b0, year_len}) begin
               month_in = '0;
               state_in = BK_MONTH;
            end else begin
               t_in    = t_ff - {7'b0, year_len};
               year_in = year_ff + 8'd1;
               wd_in   = add_mod7(wd_ff, leap ? 3'd2 : 3'd1);
            end
         end
         BK_MONTH: begin
            if (t_ff < {11'b0, mlen}) begin
               state_in = BK_DONE;
            end else begin
               t_in     = t_ff - {11'b0, mlen};
               month_in = month_ff + 4'd1;
               wd_in    = add_mod7(wd_ff, 3'(mlen - FOUR_WEEKS));
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in.second          = second_ff;
      rsp_in.minute          = min_diff[5:0];
      rsp_in.hour            = hour_ff;
      rsp_in.weekday         = add_mod7(wd_ff, mod7_small(t_ff[4:0]));
      rsp_in.year_since_1900 = year_ff;
      rsp_in.month_index     = month_ff;
      rsp_in.day_of_month    = t_ff[4:0] + 5'd1;
      rsp_in.sync_request    = sreq_ff;
      rsp_in.is_synced       = synced_ff;
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   always_ff @(posedge clock) begin
      secs_ff   <= secs_in;
      rem_ff    <= rem_in;
      mins_ff   <= mins_in;
      t_ff      <= t_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      wd_ff     <= wd_in;
      hour_ff   <= hour_in;
      second_ff <= second_in;
      sreq_ff   <= sreq_in;
      synced_ff <= synced_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/epoch_seconds_calendar_clock_top.sv */
// conversion: the back end walks Y + M steps, Y = whole years walked since 1970
//   (0..136) and M = whole months walked in the final year (0..11); Y + M peaks at
//   146 in december 2105
// the back end takes one job at a time, so its year and month walk sets the request rate
// the front takes requests at one per cycle until the job queue is full
// reset: synchronous, clears the clock to 10886400 seconds, unsynced, interval 600
// ----------------------------------------------------------------------------
// epoch_seconds_calendar_clock_top: epoch seconds real-time clock with calendar
// keeps seconds since 1970, raises resync requests and returns broken-down time
// ----------------------------------------------------------------------------
module epoch_seconds_calendar_clock_top #(
   parameter int QUEUE_DEPTH = 2   // jobs buffered between front and back, 2 or more
) (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_valid,
   output logic             req_ready,
   input  eclk_pkg::req_type req_data,
   // response channel
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output eclk_pkg::rsp_type rsp_data,
   // sync interval register write
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);
   import eclk_pkg::*;

   // front to queue
   logic    push;
   job_type push_data;
   logic    full;

   // queue to back
   logic    pop;
   job_type pop_data;
   logic    empty;

   // front: owns the seconds count, synced flag, tick count and interval;
   // an accepted tick or sync updates them in the accepting cycle, and every
   // accepted request leaves a snapshot of the new seconds value with its flags in the queue
   eclk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   // queue: lets the front keep taking requests while the back is busy
   eclk_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   // back: one job at a time
   //   pops a job, then works out days, seconds of day,
   //   minute of day, and hour with second, all by reciprocal multiplies;
   //   then one year per cycle and one month per cycle;
   //   weekday accumulates along the walk, the response sits in an output
   //   register so the next job can start while it waits to be taken
   eclk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop       (pop),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for epoch_seconds_calendar_clock_top
// drives read, tick and sync requests with random idling on both channels,
// predicts every calendar response in the testbench and compares it field by
// field, rewriting the sync interval register between traffic phases
// ----------------------------------------------------------------------------
module tb;
   import eclk_pkg::*;

   // opcode 3 has no name in the package, the block treats it as a read
   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam logic [31:0] RESET_SECONDS  = 32'd10886400;
   localparam logic [15:0] RESET_INTERVAL = 16'd600;
   // longer than the longest conversion
   localparam int          TAIL_CYCLES    = 200;
   // two queued conversions plus long random stalls stay far below this
   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          IDLE_PERCENT   = 37;
   localparam int          PRINT_LIMIT    = 40;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [15:0] csr_data;

   // predicted clock state, updated when a request is accepted
   logic [31:0] now_seconds;
   logic        synced;
   logic [15:0] tick_count;
   logic [15:0] resync_interval;

   rsp_type expected_times[$];
   int      mismatches   = 0;
   int      quiet_cycles = 0;
   // set for a whole phase to get a long stretch without any idling
   logic    no_idle      = 1'b0;

   epoch_seconds_calendar_clock_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // calendar arithmetic, full gregorian leap rule
   // ---------------------------------------------------------------------
   function automatic logic gregorian_leap(input int unsigned since_1900);
      int unsigned y;
      y = since_1900 + 1900;
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned days_in_year(input int unsigned since_1900);
      return gregorian_leap(since_1900) ? 366 : 365;
   endfunction

   function automatic int unsigned days_in_month(input int unsigned mo,
                                                 input int unsigned since_1900);
      int unsigned n;
      case (mo)
         1:             n = gregorian_leap(since_1900) ? 29 : 28;
         3, 5, 8, 10:   n = 30;
         default:       n = 31;
      endcase
      return n;
   endfunction

   // broken-down time of a seconds count, walking years then months
   function automatic rsp_type calendar_of(input logic [31:0] secs);
      rsp_type     t;
      int unsigned days;
      int unsigned yr;
      int unsigned mo;
      t         = '0;
      t.second  = 6'(secs % 60);
      t.minute  = 6'((secs / 60) % 60);
      t.hour    = 5'((secs / 3600) % 24);
      days      = secs / 86400;
      // day zero was a thursday
      t.weekday = 3'((days + 4) % 7);
      yr = 70;
      while (days >= days_in_year(yr)) begin
         days = days - days_in_year(yr);
         yr++;
      end
      mo = 0;
      while (days >= days_in_month(mo, yr)) begin
         days = days - days_in_month(mo, yr);
         mo++;
      end
      t.year_since_1900 = 8'(yr);
      t.month_index     = 4'(mo);
      t.day_of_month    = 5'(days + 1);
      return t;
   endfunction

   // advance the predicted clock by one request and queue its response
   task automatic apply_request(input req_type r);
      rsp_type e;
      logic    ask_sync;
      ask_sync = 1'b0;
      case (r.opcode)
         OP_TICK: begin
            // request check comes before the count moves
            if (!synced || tick_count >= resync_interval) begin
               ask_sync   = 1'b1;
               tick_count = '0;
            end
            now_seconds = now_seconds + 32'd1;
            tick_count  = tick_count + 16'd1;
         end
         OP_SYNC: begin
            // loading a time leaves the tick count alone
            now_seconds = r.sync_seconds;
            synced      = 1'b1;
         end
         default: begin
         end
      endcase
      e              = calendar_of(now_seconds);
      e.sync_request = ask_sync;
      e.is_synced    = synced;
      expected_times.push_back(e);
   endtask

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   task automatic send_request(input req_type r);
      // random gap before the request, none while no_idle holds
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      apply_request(r);
   endtask

   task automatic send_op(input logic [1:0] op, input logic [31:0] secs);
      req_type r;
      r.opcode       = op;
      r.sync_seconds = secs;
      send_request(r);
   endtask

   // hold off new requests until every response is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_times.size() != 0) @(posedge clock);
   endtask

   // register write, only called with nothing in flight
   task automatic write_interval(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      resync_interval = value;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
   end

   task automatic report_mismatch(input string what);
      // log stays short on a badly broken block, the count keeps going
      if (mismatches < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_times.size() == 0) begin
            report_mismatch("response with no request waiting");
         end else begin
            e = expected_times.pop_front();
            check_field("second", 32'(rsp_data.second), 32'(e.second));
            check_field("minute", 32'(rsp_data.minute), 32'(e.minute));
            check_field("hour", 32'(rsp_data.hour), 32'(e.hour));
            check_field("weekday", 32'(rsp_data.weekday), 32'(e.weekday));
            check_field("year_since_1900", 32'(rsp_data.year_since_1900),
                        32'(e.year_since_1900));
            check_field("month_index", 32'(rsp_data.month_index), 32'(e.month_index));
            check_field("day_of_month", 32'(rsp_data.day_of_month), 32'(e.day_of_month));
            check_field("sync_request", 32'(rsp_data.sync_request), 32'(e.sync_request));
            check_field("is_synced", 32'(rsp_data.is_synced), 32'(e.is_synced));
         end
      end
   end

   // watchdog: too long without any handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // clock straight out of reset, unsynced ticks ask for a sync every time
   task automatic test_reset_state();
      send_op(OP_READ, 32'd0);
      send_op(OP_TICK, 32'hFFFF_FFFF);
      send_op(OP_TICK, 32'd0);
      send_op(OP_TICK, 32'd0);
      send_op(OP_UNUSED, 32'hFFFF_FFFF);
   endtask

   // field extremes and calendar corners, each sync but the first followed by a tick across
   task automatic test_calendar_edges();
      send_op(OP_SYNC, 32'd0);
      send_op(OP_UNUSED, 32'd0);
      // seconds wrap back to the epoch
      send_op(OP_SYNC, 32'hFFFF_FFFF);
      send_op(OP_TICK, 32'd0);
      // last second of 28 feb 2000, a leap day follows
      send_op(OP_SYNC, 32'd951782399);
      send_op(OP_TICK, 32'd0);
      // last second of 28 feb 2100, not a leap year
      send_op(OP_SYNC, 32'd4107542399);
      send_op(OP_TICK, 32'd0);
      // new year 2000
      send_op(OP_SYNC, 32'd946684799);
      send_op(OP_TICK, 32'd0);
      // top bit of the count flips
      send_op(OP_SYNC, 32'h7FFF_FFFF);
      send_op(OP_TICK, 32'd0);
   endtask

   // zero interval makes every tick ask, a short interval every few ticks
   task automatic test_sync_interval();
      wait_drained();
      write_interval(16'd0);
      send_op(OP_TICK, 32'd0);
      send_op(OP_TICK, 32'd0);
      wait_drained();
      write_interval(16'd2);
      repeat (4) send_op(OP_TICK, 32'd0);
   endtask

   // phases of random traffic, one interval setting each
   task automatic test_random_traffic();
      req_type     r;
      int unsigned roll;
      int unsigned pause_at;
      logic [15:0] interval;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       interval = 16'd1;
            1:       interval = 16'hFFFF;
            2:       interval = 16'($urandom_range(2, 10));
            3:       interval = 16'($urandom_range(0, 16'hFFFF));
            4:       interval = 16'($urandom_range(3, 40));
            default: interval = RESET_INTERVAL;
         endcase
         wait_drained();
         write_interval(interval);
         no_idle  = (phase == 2);
         pause_at = $urandom_range(20, 230);
         for (int n = 0; n < 250; n++) begin
            // sender holds back until the block is empty
            if (n == pause_at) begin
               wait_drained();
            end
            roll           = $urandom_range(99);
            r.sync_seconds = $urandom();
            if (roll < 60) begin
               r.opcode = OP_TICK;
            end else if (roll < 72) begin
               r.opcode = OP_READ;
            end else if (roll < 76) begin
               r.opcode = OP_UNUSED;
            end else begin
               r.opcode = OP_SYNC;
               roll     = $urandom_range(9);
               // half the syncs land in the first years, short year walk
               if (roll < 5) begin
                  r.sync_seconds = $urandom_range(0, 32'd157766400);
               end else if (roll < 7) begin
                  case ($urandom_range(3))
                     0:       r.sync_seconds = 32'hFFFF_FFFF;
                     1:       r.sync_seconds = 32'd4107542399;
                     2:       r.sync_seconds = 32'd951868799;
                     default: r.sync_seconds = 32'd4102444799;
                  endcase
                  r.sync_seconds = r.sync_seconds - $urandom_range(0, 2);
               end
            end
            send_request(r);
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      now_seconds     = RESET_SECONDS;
      synced          = 1'b0;
      tick_count      = '0;
      resync_interval = RESET_INTERVAL;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_calendar_edges();
      test_sync_interval();
      test_random_traffic();

      wait_drained();
      // anything after the last response is a stray
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
